@@ hw/rtl/plp_pkg.sv @@
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types and constants of the piecewise-linear profile lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plp_pkg;

    // breakpoint storage
    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // signed q16.16 values and the q0.16 fraction
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = $clog2(FRAC_W);
    localparam int DIFF_W  = Q_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_W + 1;
    localparam int ENTRY_W = 2 * Q_W;

    localparam int CMD_W = 2;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [Q_W-1:0]    t_q16;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_count;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_QUERY  = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/plp_if.sv @@
// ----------------------------------------------------------------------------
// plp_req_if / plp_rsp_if
// Valid/ready channels carrying lookup requests and height results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plp_req_if import plp_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd command;
    t_q16 point_pos;
    t_q16 point_height;
    t_q16 query_pos;

    modport source (output valid, output command, output point_pos,
                    output point_height, output query_pos, input ready);
    modport sink   (input valid, input command, input point_pos,
                    input point_height, input query_pos, output ready);
endinterface

interface plp_rsp_if import plp_pkg::*; ();
    logic valid;
    logic ready;
    t_q16 height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/plp_ram.sv @@
// ----------------------------------------------------------------------------
// plp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/piecewise_linear_profile_lookup.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_profile_lookup
// Breakpoint table with binary search and linear interpolation of height.
// ----------------------------------------------------------------------------
// Requests enter on i_req (valid/ready). An append stores one breakpoint
// (point_pos, point_height) behind the last one and is dropped when the
// table is full; a clear empties the table; neither gives a result. A
// query returns one height on o_rsp (valid/ready). An empty table goes
// straight to the output state. A single entry or a position at or below
// the first breakpoint returns after the read of the first entry, a
// position at or above the last one after the read of the last entry;
// otherwise a binary search brackets the position and the states PREP,
// DIV, MUL and ADD interpolate, with DIV skipped when the fraction is
// zero or full scale. The search makes one read of the breakpoint RAM
// per cycle, and the restoring divider yields one fraction bit per cycle.
// i_req.ready is high only while the sequencer is idle. A finished height
// waits in the output register; if the receiver stalls, the sequencer
// holds in its final state until the register frees up, while the next
// request may already be taken before the previous height is read.
// Reset empties the table and drops any pending result; the breakpoint
// RAM is not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_profile_lookup import plp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plp_req_if.sink    i_req,
    plp_rsp_if.source  o_rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P0   = 4'd1;
    localparam logic [3:0] S_PN   = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_PREP = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]               r_state, n_state;
    t_count                   r_count, n_count;
    t_q16                     r_at, n_at;
    t_q16                     r_plo, n_plo, r_hlo, n_hlo;
    t_q16                     r_phi, n_phi, r_hhi, n_hhi;
    t_addr                    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [Q_W-1:0]           r_rem, n_rem, r_d, n_d;
    logic [FRAC_W-1:0]        r_quo, n_quo;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [DIFF_W-1:0] r_dh, n_dh;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    t_q16                     r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    t_q16                     r_out_height, n_out_height;

    logic                   req_fire;
    logic                   ram_we;
    t_addr                  ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    t_q16                   rd_pos, rd_h;
    logic                   probe_le;
    t_addr                  sr_lo, sr_hi, sr_gap, sr_mid;
    logic signed [DIFF_W-1:0] num, pos_span;
    logic [Q_W:0]           rem2;
    logic                   rem_ge;

    assign i_req.ready  = (r_state == S_IDLE);
    assign req_fire     = i_req.valid && i_req.ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.height = r_out_height;

    assign ram_we = req_fire && (i_req.command == CMD_APPEND)
                    && (r_count < t_count'(TABLE_DEPTH));

    plp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_req.point_pos, i_req.point_height}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pos   = t_q16'(ram_rdata[ENTRY_W-1:Q_W]);
    assign rd_h     = t_q16'(ram_rdata[Q_W-1:0]);
    assign probe_le = (rd_pos <= r_at);

    // search interval after this cycle's probe, or the full table range outside the search
    always_comb begin
        if (r_state == S_SRCH) begin
            sr_lo = probe_le ? r_mid : r_lo;
            sr_hi = probe_le ? r_hi : r_mid;
        end else begin
            sr_lo = '0;
            sr_hi = t_addr'(r_count - t_count'(1));
        end
        sr_gap = sr_hi - sr_lo;
        sr_mid = sr_lo + (sr_gap >> 1);
    end

    assign num      = {r_at[Q_W-1], r_at} - {r_plo[Q_W-1], r_plo};
    assign pos_span = {r_phi[Q_W-1], r_phi} - {r_plo[Q_W-1], r_plo};
    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, r_d});

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_at         = r_at;
        n_plo        = r_plo;
        n_hlo        = r_hlo;
        n_phi        = r_phi;
        n_hhi        = r_hhi;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_rem        = r_rem;
        n_d          = r_d;
        n_quo        = r_quo;
        n_step       = r_step;
        n_dh         = r_dh;
        n_prod       = r_prod;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_height = r_out_height;
        ram_raddr    = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.command)
                        CMD_APPEND: begin
                            if (ram_we) begin
                                n_count = r_count + t_count'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_at = i_req.query_pos;
                            if (r_count == '0) begin
                                n_res   = '0;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_P0;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_P0: begin
                n_plo = rd_pos;
                n_hlo = rd_h;
                if ((r_count == t_count'(1)) || (r_at <= rd_pos)) begin
                    n_res   = rd_h;
                    n_state = S_OUT;
                end else begin
                    ram_raddr = t_addr'(r_count - t_count'(1));
                    n_state   = S_PN;
                end
            end
            S_PN, S_SRCH: begin
                if (r_state == S_PN) begin
                    n_phi = rd_pos;
                    n_hhi = rd_h;
                end else if (probe_le) begin
                    n_plo = rd_pos;
                    n_hlo = rd_h;
                end else begin
                    n_phi = rd_pos;
                    n_hhi = rd_h;
                end
                n_lo = sr_lo;
                n_hi = sr_hi;
                if ((r_state == S_PN) && (r_at >= rd_pos)) begin
                    n_res   = rd_h;
                    n_state = S_OUT;
                end else if (sr_gap > t_addr'(1)) begin
                    ram_raddr = sr_mid;
                    n_mid     = sr_mid;
                    n_state   = S_SRCH;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_dh   = {r_hhi[Q_W-1], r_hhi} - {r_hlo[Q_W-1], r_hlo};
                n_quo  = '0;
                n_step = '0;
                n_rem  = num[Q_W-1:0];
                n_d    = pos_span[Q_W-1:0];
                priority if ((pos_span <= 0) || (num <= 0)) begin
                    n_state = S_MUL;
                end else if (num >= pos_span) begin
                    n_quo   = '1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one fraction bit per cycle
                n_rem  = rem_ge ? Q_W'(rem2 - {1'b0, r_d}) : rem2[Q_W-1:0];
                n_quo  = {r_quo[FRAC_W-2:0], rem_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(FRAC_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_dh * $signed({1'b0, r_quo}));
                n_state = S_ADD;
            end
            S_ADD: begin
                // floor shift by the fraction width, result stays in range
                n_res   = r_hlo + t_q16'(r_prod[FRAC_W+Q_W-1:FRAC_W]);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_height = r_res;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_at         <= n_at;
        r_plo        <= n_plo;
        r_hlo        <= n_hlo;
        r_phi        <= n_phi;
        r_hhi        <= n_hhi;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_rem        <= n_rem;
        r_d          <= n_d;
        r_quo        <= n_quo;
        r_step       <= n_step;
        r_dh         <= n_dh;
        r_prod       <= n_prod;
        r_res        <= n_res;
        r_out_height <= n_out_height;
    end

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(TABLE_DEPTH))
        else $error("breakpoint count beyond table depth");

    // an append into a full table leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && (i_req.command == CMD_APPEND)
         && (r_count == t_count'(TABLE_DEPTH)))
        |=> (r_count == t_count'(TABLE_DEPTH)))
        else $error("append into full table changed the count");

    // every probe lies strictly inside the search interval
    a_probe_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((r_mid > r_lo) && (r_mid < r_hi)))
        else $error("search probe outside bracketing pair");

endmodule

`default_nettype wire
